// File: rtl/cfvdl_pkg.sv
package cfvdl_pkg;

  // Defaults for the top-level parameters
  localparam int unsigned RingDepthDef = 262144;
  localparam int unsigned ChannelsDef  = 2;

  // Field widths
  localparam int unsigned SampleW = 24;
  localparam int unsigned DelayW  = 18;
  localparam int unsigned FracW   = 16;

  // Configuration port
  localparam int unsigned PAddrW  = 3;
  localparam int unsigned PDataW  = 32;

  // Register reset values
  localparam logic [DelayW-1:0] MaxDelayRst = 18'd192000;
  localparam logic [FracW-1:0]  FadeStepRst = 16'd46;

  // Register indexes (word address bit of paddr)
  localparam logic REG_MAX_DELAY = 1'b0;
  localparam logic REG_FADE_STEP = 1'b1;

  typedef logic signed [SampleW-1:0] sample_t;
  typedef logic [DelayW-1:0]         delay_t;
  typedef logic [FracW-1:0]          frac_t;

  // How a tap is sourced once the ring read returns
  typedef struct packed {
    logic fwd;    // zero delay: take the frame written with this transaction
    logic blank;  // entry never written since reset: reads as zero
  } tap_sel_t;

endpackage

// File: rtl/crossfading_variable_delay_line_top.sv
// Stereo variable delay line with a linear crossfade between delays.
// Input channel (in_valid_i/in_ready_o): one frame per transaction, with
// delay_request_i, left_in_i and right_in_i. Output channel
// (out_valid_o/out_ready_i): one result per input frame, left_out_o,
// right_out_o and fading_o, in order.
// Throughput: one frame per cycle unless the output stalls. The ring memory has
// one write port and two read ports, so the frame write and both taps are
// served in the cycle the frame is accepted. The result goes through the ring
// read, the weight multiply, the sum and the output register.
// Stalls: each stage moves on when the next is empty or moving, so frames
// keep entering while a result waits, until all three stages are full.
// Reset: registers return to their defaults (max_delay 192000, fade_step 46)
// and the delay state is cleared. The ring is not swept: a fill count marks
// how much of it holds written frames, and older taps read as zero, so the
// block accepts frames right after reset. RING_DEPTH is a power of two.
// Configuration (APB, pready always high): max_delay at 0x0, fade_step at
// 0x4; write only while the block is idle.
module crossfading_variable_delay_line_top #(
  parameter int unsigned RING_DEPTH = cfvdl_pkg::RingDepthDef,
  parameter int unsigned CHANNELS   = cfvdl_pkg::ChannelsDef
) (
  input  logic                                clk_i,
  input  logic                                rst_ni,
  // configuration
  input  logic                                psel,
  input  logic                                penable,
  input  logic                                pwrite,
  input  logic [cfvdl_pkg::PAddrW-1:0]        paddr,
  input  logic [cfvdl_pkg::PDataW-1:0]        pwdata,
  output logic [cfvdl_pkg::PDataW-1:0]        prdata,
  output logic                                pready,
  // input frames
  input  logic                                in_valid_i,
  output logic                                in_ready_o,
  input  cfvdl_pkg::delay_t                   delay_request_i,
  input  cfvdl_pkg::sample_t                  left_in_i,
  input  cfvdl_pkg::sample_t                  right_in_i,
  // results
  output logic                                out_valid_o,
  input  logic                                out_ready_i,
  output cfvdl_pkg::sample_t                  left_out_o,
  output cfvdl_pkg::sample_t                  right_out_o,
  output logic                                fading_o
);
  import cfvdl_pkg::*;

  localparam int unsigned AW    = $clog2(RING_DEPTH);
  localparam int unsigned EW    = (AW > DelayW) ? AW : DelayW;
  localparam int unsigned WordW = CHANNELS * SampleW;
  localparam int unsigned WtW   = FracW + 1;
  localparam int unsigned ProdW = SampleW + WtW + 1;
  localparam int unsigned SumW  = ProdW + 1;

  // -------------------------------------------------------------------------
  // Configuration registers
  // -------------------------------------------------------------------------
  delay_t max_delay_q;
  frac_t  fade_step_q;
  logic   cfg_wr;

  assign pready = 1'b1;
  assign cfg_wr = psel && penable && pwrite;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      max_delay_q <= MaxDelayRst;
      fade_step_q <= FadeStepRst;
    end else if (cfg_wr) begin
      case (paddr[2])
        REG_MAX_DELAY: max_delay_q <= pwdata[DelayW-1:0];
        REG_FADE_STEP: fade_step_q <= pwdata[FracW-1:0];
        default: ;
      endcase
    end
  end

  always_comb begin
    case (paddr[2])
      REG_MAX_DELAY: prdata = PDataW'(max_delay_q);
      REG_FADE_STEP: prdata = PDataW'(fade_step_q);
      default:       prdata = '0;
    endcase
  end

  // -------------------------------------------------------------------------
  // Handshake: a stage loads when it is empty or its content moves on
  // -------------------------------------------------------------------------
  logic v1_q, v2_q, vo_q;
  logic rdy1, rdy2, rdy3, accept;

  assign rdy3       = !vo_q || out_ready_i;
  assign rdy2       = !v2_q || rdy3;
  assign rdy1       = !v1_q || rdy2;
  assign in_ready_o = rdy1;
  assign accept     = in_valid_i && rdy1;

  // -------------------------------------------------------------------------
  // Delay and fade state, updated at accept
  // -------------------------------------------------------------------------
  delay_t          old_delay_q, new_delay_q;
  logic            fade_on_q;
  frac_t           frac_q;
  logic [AW-1:0]   wr_idx_q;
  logic [AW:0]     fill_q;

  delay_t          req_c, old_n, new_n, old_d;
  logic            chg, on_n, fade_on_d;
  frac_t           frac_n, frac_d;
  logic [FracW:0]  frac_sum;

  always_comb begin
    req_c = (delay_request_i > max_delay_q) ? max_delay_q : delay_request_i;
    chg   = (req_c != new_delay_q);
    // a new target restarts the fade; the old tap is kept if already fading
    old_n  = (chg && !fade_on_q) ? new_delay_q : old_delay_q;
    new_n  = chg ? req_c : new_delay_q;
    frac_n = chg ? '0 : frac_q;
    on_n   = chg || fade_on_q;

    frac_sum  = {1'b0, frac_n} + {1'b0, fade_step_q};
    old_d     = old_n;
    fade_on_d = on_n;
    frac_d    = frac_n;
    if (on_n) begin
      if (frac_sum[FracW]) begin
        // fade complete
        fade_on_d = 1'b0;
        frac_d    = '0;
        old_d     = new_n;
      end else begin
        frac_d = frac_sum[FracW-1:0];
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      old_delay_q <= '0;
      new_delay_q <= '0;
      fade_on_q   <= 1'b0;
      frac_q      <= '0;
      wr_idx_q    <= '0;
      fill_q      <= '0;
    end else if (accept) begin
      old_delay_q <= old_d;
      new_delay_q <= new_n;
      fade_on_q   <= fade_on_d;
      frac_q      <= frac_d;
      wr_idx_q    <= wr_idx_q + 1'b1;
      if (fill_q != (AW+1)'(RING_DEPTH)) begin
        fill_q <= fill_q + 1'b1;
      end
    end
  end

  // -------------------------------------------------------------------------
  // Tap addresses and sourcing
  // -------------------------------------------------------------------------
  logic [EW-1:0] dn_ext, do_ext;
  logic [AW-1:0] dn_mod, do_mod, ra_n, ra_o;
  tap_sel_t      sel_n, sel_o;

  assign dn_ext = EW'(new_n);
  assign do_ext = EW'(old_d);
  assign dn_mod = dn_ext[AW-1:0];
  assign do_mod = do_ext[AW-1:0];
  assign ra_n   = wr_idx_q - dn_mod;
  assign ra_o   = wr_idx_q - do_mod;

  always_comb begin
    sel_n.fwd   = (dn_mod == '0);
    sel_n.blank = !sel_n.fwd && ({1'b0, dn_mod} > fill_q);
    sel_o.fwd   = (do_mod == '0);
    sel_o.blank = !sel_o.fwd && ({1'b0, do_mod} > fill_q);
  end

  // Frame packed for the ring
  logic [WordW-1:0] wr_word;

  always_comb begin
    for (int ch = 0; ch < CHANNELS; ch++) begin
      wr_word[ch*SampleW +: SampleW] = (ch == 0) ? left_in_i : right_in_i;
    end
  end

  // -------------------------------------------------------------------------
  // Ring memory: one write port, two registered read ports
  // -------------------------------------------------------------------------
  logic [WordW-1:0] ring_mem [RING_DEPTH];
  logic [WordW-1:0] rd_n_q, rd_o_q;

  always_ff @(posedge clk_i) begin
    if (accept) begin
      ring_mem[wr_idx_q] <= wr_word;
      rd_n_q             <= ring_mem[ra_n];
      rd_o_q             <= ring_mem[ra_o];
    end
  end

  // -------------------------------------------------------------------------
  // Stage 1: side data that travels with the ring read
  // -------------------------------------------------------------------------
  logic [WordW-1:0] frame1_q;
  tap_sel_t         sel_n1_q, sel_o1_q;
  logic             fade1_q;
  frac_t            frac1_q;

  always_ff @(posedge clk_i) begin
    if (accept) begin
      frame1_q <= wr_word;
      sel_n1_q <= sel_n;
      sel_o1_q <= sel_o;
      fade1_q  <= fade_on_d;
      frac1_q  <= frac_d;
    end
  end

  // Tap selection and weighting; no fade weighs the new tap by one
  sample_t              tap_n [CHANNELS];
  sample_t              tap_o [CHANNELS];
  logic [WtW-1:0]       wt_n, wt_o;
  logic signed [ProdW-1:0] prod_n [CHANNELS];
  logic signed [ProdW-1:0] prod_o [CHANNELS];

  always_comb begin
    wt_n = fade1_q ? {1'b0, frac1_q} : {1'b1, {FracW{1'b0}}};
    wt_o = {1'b1, {FracW{1'b0}}} - wt_n;
    for (int ch = 0; ch < CHANNELS; ch++) begin
      if (sel_n1_q.fwd) begin
        tap_n[ch] = frame1_q[ch*SampleW +: SampleW];
      end else if (sel_n1_q.blank) begin
        tap_n[ch] = '0;
      end else begin
        tap_n[ch] = rd_n_q[ch*SampleW +: SampleW];
      end
      if (sel_o1_q.fwd) begin
        tap_o[ch] = frame1_q[ch*SampleW +: SampleW];
      end else if (sel_o1_q.blank) begin
        tap_o[ch] = '0;
      end else begin
        tap_o[ch] = rd_o_q[ch*SampleW +: SampleW];
      end
      prod_n[ch] = tap_n[ch] * $signed({1'b0, wt_n});
      prod_o[ch] = tap_o[ch] * $signed({1'b0, wt_o});
    end
  end

  // -------------------------------------------------------------------------
  // Stage 2: registered products
  // -------------------------------------------------------------------------
  logic signed [ProdW-1:0] prod_n2_q [CHANNELS];
  logic signed [ProdW-1:0] prod_o2_q [CHANNELS];
  logic                    fade2_q;

  always_ff @(posedge clk_i) begin
    if (rdy2 && v1_q) begin
      prod_n2_q <= prod_n;
      prod_o2_q <= prod_o;
      fade2_q   <= fade1_q;
    end
  end

  // Sum and floor by 2^16 (arithmetic shift truncates toward minus infinity)
  logic signed [SumW-1:0] mix_sum [CHANNELS];
  sample_t                mix     [CHANNELS];

  always_comb begin
    for (int ch = 0; ch < CHANNELS; ch++) begin
      mix_sum[ch] = SumW'(prod_n2_q[ch]) + SumW'(prod_o2_q[ch]);
      mix[ch]     = mix_sum[ch][FracW +: SampleW];
    end
  end

  // -------------------------------------------------------------------------
  // Stage 3: output register
  // -------------------------------------------------------------------------
  sample_t out_q [CHANNELS];
  logic    fade_o_q;

  always_ff @(posedge clk_i) begin
    if (rdy3 && v2_q) begin
      out_q    <= mix;
      fade_o_q <= fade2_q;
    end
  end

  // Stage valid bits
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      v1_q <= 1'b0;
      v2_q <= 1'b0;
      vo_q <= 1'b0;
    end else begin
      if (rdy1) begin
        v1_q <= accept;
      end
      if (rdy2) begin
        v2_q <= v1_q;
      end
      if (rdy3) begin
        vo_q <= v2_q;
      end
    end
  end

  assign out_valid_o = vo_q;
  assign left_out_o  = out_q[0];
  assign right_out_o = (CHANNELS > 1) ? out_q[CHANNELS-1] : '0;
  assign fading_o    = fade_o_q;

endmodule
